[design/ppsb_pkg.sv]
// ----------------------------------------------------------------------------
// ppsb_pkg
// Shared constants, register indexes, controller states and the command and
// status bundles that join the phase stack controller and its datapath.
// ----------------------------------------------------------------------------
package ppsb_pkg;

    // Store geometry and cell width
    localparam int MAX_PULSES     = 64;
    localparam int MAX_PHASE_BINS = 256;
    localparam int ACC_W          = 48;
    localparam int ROW_W          = 6;
    localparam int COL_W          = 8;
    localparam int ADDR_W         = ROW_W + COL_W;
    localparam int NP_W           = 7;
    localparam int NB_W           = 9;

    // Serial divider: one quotient bit per step over a 32-bit dividend
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Stream widths
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 64;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_MIN      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_BIN_W    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_MIN      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_PULSES     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_PHASE_BINS = 3'd4;

    // Item kinds carried in the input tuser
    localparam logic MODE_ACC  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_FETCH,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_we;
        logic load;
        logic div_step;
        logic check;
        logic fetch;
        logic update;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic hit;
        logic out_free;
    } sts_t;

endpackage

[design/ppsb_ctrl.sv]
// ----------------------------------------------------------------------------
// ppsb_ctrl
// Sequencer for the phase stack: clearing sweep after reset, item intake,
// serial division, range check, read-modify-write of one cell and hand-off
// of the result to the output register.
// ----------------------------------------------------------------------------
module ppsb_ctrl
    import ppsb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_mode,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_next;

    // State and step counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    div_cnt_next = '0;
                    state_next   = (in_mode == MODE_READ) ? ST_FETCH : ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.hit ? ST_FETCH : ST_RESULT;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A result is only moved into a free output register.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output register busy");

    // An accepted accumulate item starts the divider from step zero.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && in_mode == MODE_ACC)
        |=> (state_reg == ST_DIV && div_cnt_reg == '0))
        else $error("divider not started on accumulate item");

    // The range check follows the full count of division steps.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK)
        |-> ($past(state_reg) == ST_DIV && $past(div_cnt_reg) == DIV_LAST))
        else $error("range check reached before division finished");

    // The cell update always uses the data of the fetch just before it.
    a_fetch_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> $past(cmd.fetch))
        else $error("cell update without preceding fetch");
`endif

endmodule

[design/ppsb_dpath.sv]
// ----------------------------------------------------------------------------
// ppsb_dpath
// Datapath of the phase stack: configuration registers, item capture, a
// restoring serial divider for the phase column, the cell store with its
// clearing counter, the saturating adder and the output register.
// ----------------------------------------------------------------------------
module ppsb_dpath
    import ppsb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  in_tdata,
    input  logic                   in_tuser,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_tdata,
    output logic                   out_tuser
);

    // Configuration registers
    logic [31:0]     phase_min_reg;
    logic [30:0]     phase_bin_width_reg;
    logic [31:0]     pulse_min_reg;
    logic [NP_W-1:0] num_pulses_reg;
    logic [NB_W-1:0] num_phase_bins_reg;

    // Item registers
    logic              mode_reg;
    logic [31:0]       weight_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic              row_ok_reg;
    logic              div_ok_reg;
    logic              landed_reg;
    logic [31:0]       num_reg;
    logic [30:0]       rem_reg;
    logic [ACC_W-1:0]  rd_data_reg;
    logic [ACC_W-1:0]  val_reg;

    // Clearing counter and output register
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              out_valid_reg;
    logic              out_landed_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ACC_W-1:0]  out_val_reg;

    // Cell store
    logic [ACC_W-1:0]  mem [MAX_PULSES * MAX_PHASE_BINS];

    // Unpacked input fields
    logic [31:0]       in_phase;
    logic [31:0]       in_pulse;
    logic [31:0]       in_weight;
    logic [ROW_W-1:0]  in_read_row;
    logic [COL_W-1:0]  in_read_col;

    logic [NP_W-1:0]   np_eff;
    logic [NB_W-1:0]   nb_eff;
    logic [32:0]       diff;
    logic [32:0]       rowq;
    logic [31:0]       rem_sh;
    logic [31:0]       den;
    logic              q_bit;
    logic              col_ok;
    logic [ADDR_W-1:0] cell_addr;
    logic [ACC_W:0]    sum_wide;
    logic [ACC_W-1:0]  sum_sat;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ACC_W-1:0]  mem_wdata;

    assign in_phase    = in_tdata[31:0];
    assign in_pulse    = in_tdata[63:32];
    assign in_weight   = in_tdata[95:64];
    assign in_read_row = in_tdata[96 +: ROW_W];
    assign in_read_col = in_tdata[96 + ROW_W +: COL_W];

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_min_reg       <= '0;
            phase_bin_width_reg <= 31'd65536;
            pulse_min_reg       <= '0;
            num_pulses_reg      <= NP_W'(MAX_PULSES);
            num_phase_bins_reg  <= NB_W'(MAX_PHASE_BINS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PHASE_MIN:      phase_min_reg       <= cfg_wdata;
                REG_PHASE_BIN_W:    phase_bin_width_reg <= cfg_wdata[30:0];
                REG_PULSE_MIN:      pulse_min_reg       <= cfg_wdata;
                REG_NUM_PULSES:     num_pulses_reg      <= cfg_wdata[NP_W-1:0];
                REG_NUM_PHASE_BINS: num_phase_bins_reg  <= cfg_wdata[NB_W-1:0];
                default:            ;
            endcase
        end
    end

    // Counts clamped to the size of the store
    assign np_eff = (num_pulses_reg > NP_W'(MAX_PULSES)) ? NP_W'(MAX_PULSES)
                                                         : num_pulses_reg;
    assign nb_eff = (num_phase_bins_reg > NB_W'(MAX_PHASE_BINS))
                  ? NB_W'(MAX_PHASE_BINS) : num_phase_bins_reg;

    // Signed offsets of the phase and the pulse number
    assign diff = {in_phase[31], in_phase} - {phase_min_reg[31], phase_min_reg};
    assign rowq = {in_pulse[31], in_pulse} - {pulse_min_reg[31], pulse_min_reg};

    // One restoring division step; the remainder stays below the divisor
    assign den    = {1'b0, phase_bin_width_reg};
    assign rem_sh = {rem_reg, num_reg[31]};
    assign q_bit  = (rem_sh >= den);

    // After the last step num_reg holds the quotient
    assign col_ok    = (num_reg < 32'(nb_eff));
    assign sts.hit   = div_ok_reg && row_ok_reg && col_ok;
    assign cell_addr = {row_reg, col_reg};

    // Item capture, division and result assembly
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= in_tuser;
            weight_reg <= in_weight;
            rem_reg    <= '0;
            num_reg    <= diff[31:0];
            div_ok_reg <= !diff[32] && (phase_bin_width_reg != '0);
            row_ok_reg <= !rowq[32] && (rowq[31:0] < 32'(np_eff));
            if (in_tuser == MODE_READ)
            begin
                row_reg    <= in_read_row;
                col_reg    <= in_read_col;
                landed_reg <= 1'b1;
            end
            else
            begin
                row_reg    <= rowq[ROW_W-1:0];
                col_reg    <= '0;
                landed_reg <= 1'b0;
            end
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[30:0], q_bit};
            rem_reg <= q_bit ? 31'(rem_sh - den) : rem_sh[30:0];
        end
        else if (cmd.check)
        begin
            landed_reg <= sts.hit;
            col_reg    <= num_reg[COL_W-1:0];
        end
        else if (cmd.update)
        begin
            val_reg <= (mode_reg == MODE_READ) ? rd_data_reg : sum_sat;
        end
    end

    // Saturating addition of the weight to the fetched cell
    always_comb
    begin
        sum_wide = {rd_data_reg[ACC_W-1], rd_data_reg}
                 + (ACC_W + 1)'(signed'(weight_reg));
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
        begin
            sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    // Clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_we)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clr_last = &clr_cnt_reg;

    // Single write port shared by the clearing sweep and the cell update
    assign mem_we    = cmd.clr_we || (cmd.update && mode_reg == MODE_ACC);
    assign mem_waddr = cmd.clr_we ? clr_cnt_reg : cell_addr;
    assign mem_wdata = cmd.clr_we ? '0 : sum_sat;

    // Cell store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= mem[cell_addr];
        end
    end

    // Output register; a dropped item leaves all fields at zero
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_landed_reg <= landed_reg;
            out_row_reg    <= landed_reg ? row_reg : '0;
            out_col_reg    <= landed_reg ? col_reg : '0;
            out_val_reg    <= landed_reg ? val_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tuser = out_landed_reg;
    assign out_tdata = {{(OUT_TDATA_W - ROW_W - COL_W - ACC_W){1'b0}},
                        out_val_reg, out_col_reg, out_row_reg};

endmodule

[design/pulse_phase_stack_binner_unit.sv]
// ----------------------------------------------------------------------------
// pulse_phase_stack_binner_unit
// Weighted two-dimensional histogram over pulse number and rotation phase.
//
// Items enter on the s_axis channel. tuser selects the kind: accumulate adds
// the weight to the cell at row pulse_no - pulse_min and column
// floor((phase - phase_min) / phase_bin_width) when both lie inside the
// configured counts and the bin width is not zero, read returns one stored
// cell. Every item gives exactly one result on the m_axis channel; tuser
// there is set when a cell was hit or read, and a dropped item returns zero
// fields. An accumulate item that lands passes from acceptance through the
// bit-serial divider, then range check, cell fetch, saturating update and
// hand-off, before the next item is accepted. A dropped accumulate skips the
// fetch and the update, and a read item skips the divider and range check.
// After reset all 16384 cells of the store are swept to zero, one cell a
// cycle; s_axis_tready stays low meanwhile, configuration writes are taken.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and worked on, and waits only at the hand-off.
// ----------------------------------------------------------------------------
module pulse_phase_stack_binner_unit
    import ppsb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // phase[31:0], pulse_no[63:32], weight[95:64], read_row[101:96],
    // read_col[109:102], zero pad[111:110]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic                   s_axis_tuser,
    // Result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // row[5:0], col[13:6], cell_value[61:14], zero pad[63:62]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // landed[0]
    output logic                   m_axis_tuser
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    ppsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Divider, cell store and output register
    ppsb_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tdata (m_axis_tdata),
        .out_tuser (m_axis_tuser)
    );

endmodule

[test/tb_pulse_phase_stack_binner_unit.sv]
// ----------------------------------------------------------------------------
// tb_pulse_phase_stack_binner_unit
// Self-checking bench for the pulse and phase histogram unit. A checker class
// keeps its own copy of the cell store and registers, works out the result
// of every item taken on the input stream and compares each result item
// field by field. Directed items cover the field extremes, dropped items,
// zero bin width, zero and clamped counts and reads of cleared cells. The
// random part then aims most accumulates at cells inside the current
// setting, across many settings and under varying back-pressure.
// ----------------------------------------------------------------------------
module tb_pulse_phase_stack_binner_unit;
    import ppsb_pkg::*;

    // Longest quiet stretch is the clear sweep of the whole store after reset;
    // other stretches come from the divider, sender gaps and the long hold-off.
    localparam int STALL_LIMIT = 60000;
    localparam int HOLD_LEN    = 400;
    localparam int CHUNK_ITEMS = 70;

    typedef struct packed {
        logic              landed;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ACC_W-1:0]  value;
    } cell_result_t;

    // Mirror of the histogram store and registers, plus the results due.
    class binner_checker;
        logic signed [ACC_W-1:0] stack_copy [MAX_PULSES*MAX_PHASE_BINS];
        logic [31:0]     phase_min;
        logic [30:0]     bin_width;
        logic [31:0]     pulse_min;
        logic [NP_W-1:0] num_pulses;
        logic [NB_W-1:0] num_bins;
        cell_result_t    due_results [$];
        int errors;
        int items_n;
        int reads_n;
        int checked_n;
        int landed_n;
        int dropped_n;

        function new();
            foreach (stack_copy[i])
            begin
                stack_copy[i] = '0;
            end
            phase_min  = '0;
            bin_width  = 31'd65536;
            pulse_min  = '0;
            num_pulses = NP_W'(MAX_PULSES);
            num_bins   = NB_W'(MAX_PHASE_BINS);
            errors     = 0;
            items_n    = 0;
            reads_n    = 0;
            checked_n  = 0;
            landed_n   = 0;
            dropped_n  = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] v);
            case (a)
                REG_PHASE_MIN:      phase_min  = v;
                REG_PHASE_BIN_W:    bin_width  = v[30:0];
                REG_PULSE_MIN:      pulse_min  = v;
                REG_NUM_PULSES:     num_pulses = v[NP_W-1:0];
                REG_NUM_PHASE_BINS: num_bins   = v[NB_W-1:0];
                default:            ;
            endcase
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Work out the result of one accepted item and update the store copy.
        function void take_item(logic mode, logic [IN_TDATA_W-1:0] d);
            cell_result_t due;
            longint diff;
            longint den;
            longint colq;
            longint rowq;
            longint sum;
            longint top;
            longint np;
            longint nb;
            int idx;
            due = '0;
            items_n++;
            if (mode == MODE_READ)
            begin
                reads_n++;
                due.landed = 1'b1;
                due.row    = d[101:96];
                due.col    = d[109:102];
                due.value  = stack_copy[{due.row, due.col}];
            end
            else if (bin_width != '0)
            begin
                np = longint'(num_pulses);
                if (np > MAX_PULSES)
                    np = MAX_PULSES;
                nb = longint'(num_bins);
                if (nb > MAX_PHASE_BINS)
                    nb = MAX_PHASE_BINS;
                den  = longint'(bin_width);
                diff = longint'($signed(d[31:0])) - longint'($signed(phase_min));
                // Floor division, so negative differences round downwards.
                if (diff >= 0)
                    colq = diff / den;
                else
                    colq = -((-diff + den - 1) / den);
                rowq = longint'($signed(d[63:32])) - longint'($signed(pulse_min));
                if (colq >= 0 && colq < nb && rowq >= 0 && rowq < np)
                begin
                    idx = int'(rowq) * MAX_PHASE_BINS + int'(colq);
                    top = (longint'(1) <<< (ACC_W - 1)) - 1;
                    sum = longint'(stack_copy[idx]) + longint'($signed(d[95:64]));
                    if (sum > top)
                        sum = top;
                    else if (sum < -top - 1)
                        sum = -top - 1;
                    stack_copy[idx] = sum[ACC_W-1:0];
                    due.landed = 1'b1;
                    due.row    = rowq[ROW_W-1:0];
                    due.col    = colq[COL_W-1:0];
                    due.value  = sum[ACC_W-1:0];
                end
            end
            due_results.push_back(due);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Compare one result item with the oldest result still due.
        task check_result(logic landed, logic [OUT_TDATA_W-1:0] d);
            cell_result_t due;
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("result with none due: landed %0b row %0d col %0d",
                                          landed, d[5:0], d[13:6]));
            end
            else
            begin
                due = due_results.pop_front();
                checked_n++;
                if (due.landed)
                    landed_n++;
                else
                    dropped_n++;
                if (landed !== due.landed)
                    report_mismatch($sformatf("result %0d: landed %0b, want %0b",
                                              checked_n, landed, due.landed));
                if (d[5:0] !== due.row)
                    report_mismatch($sformatf("result %0d: row %0d, want %0d",
                                              checked_n, d[5:0], due.row));
                if (d[13:6] !== due.col)
                    report_mismatch($sformatf("result %0d: col %0d, want %0d",
                                              checked_n, d[13:6], due.col));
                if (d[61:14] !== due.value)
                    report_mismatch($sformatf("result %0d: cell_value %0d, want %0d",
                                              checked_n, $signed(d[61:14]),
                                              $signed(due.value)));
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // phase, pulse_no, weight, read_row, read_col, zero pad (lowest first)
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // mode
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // row, col, cell_value, zero pad (lowest first)
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // landed
    logic                   m_axis_tuser;

    binner_checker chk = new();

    int send_idle_pct = 22;
    int recv_idle_pct = 74;
    int hold_ticket = 0;
    int quiet_cycles = 0;
    int n_settings = 0;

    // Setting currently programmed, used to aim the random accumulates.
    logic [31:0]     cur_pm = '0;
    logic [30:0]     cur_bw = 31'd65536;
    logic [31:0]     cur_pmin = '0;
    logic [NP_W-1:0] cur_np = NP_W'(MAX_PULSES);
    logic [NB_W-1:0] cur_nb = NB_W'(MAX_PHASE_BINS);

    pulse_phase_stack_binner_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Monitor: register writes, accepted items and results, plus the watchdog.
    always @(posedge clk)
    begin
        if (cfg_we)
            chk.set_reg(cfg_addr, cfg_wdata);
        if (s_axis_tvalid && s_axis_tready)
            chk.take_item(s_axis_tuser, s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready)
            chk.check_result(m_axis_tuser, m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles, %0d results still due.",
                     quiet_cycles, chk.pending());
            $display("tb_pulse_phase_stack_binner_unit NOT OK");
            $finish;
        end
    end

    // Receiver: random back-pressure, with a long hold-off on request.
    initial
    begin
        int seen_ticket;
        int hold_left;
        seen_ticket = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != seen_ticket)
            begin
                seen_ticket = hold_ticket;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    // Program all five registers; unused upper bits carry junk, and one
    // write goes to an index past the last register.
    task automatic apply_setting(input logic [31:0] pm, input logic [30:0] bw,
                                 input logic [31:0] pmin, input logic [NP_W-1:0] np,
                                 input logic [NB_W-1:0] nb);
        cfg_write(REG_NUM_PHASE_BINS + 3'(32'd1 + $urandom_range(0, 2)), $urandom());
        cfg_write(REG_PHASE_MIN, pm);
        cfg_write(REG_PHASE_BIN_W, {1'($urandom()), bw});
        cfg_write(REG_PULSE_MIN, pmin);
        cfg_write(REG_NUM_PULSES, {25'($urandom()), np});
        cfg_write(REG_NUM_PHASE_BINS, {23'($urandom()), nb});
        cfg_we <= 1'b0;
        cur_pm   = pm;
        cur_bw   = bw;
        cur_pmin = pmin;
        cur_np   = np;
        cur_nb   = nb;
        n_settings++;
    endtask

    // Offer one item, wait for it to be taken, then maybe leave a gap.
    task automatic push_item(input logic mode, input logic [IN_TDATA_W-1:0] d);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 40);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= 1'($urandom());
            s_axis_tdata  <= {2'b00, 14'($urandom()), $urandom(), $urandom(), $urandom()};
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic offer_acc(input logic [31:0] ph, input logic [31:0] pu,
                             input logic [31:0] wt);
        push_item(MODE_ACC, {2'b00, 8'($urandom()), 6'($urandom()), wt, pu, ph});
    endtask

    task automatic offer_read(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        push_item(MODE_READ, {2'b00, c, r, $urandom(), $urandom(), $urandom()});
    endtask

    task automatic sender_stop();
        s_axis_tvalid <= 1'b0;
    endtask

    // Hold the sender until every result due has arrived.
    task automatic wait_drained();
        @(negedge clk);
        while (chk.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic random_setting();
        logic [31:0]     pm;
        logic [30:0]     bw;
        logic [31:0]     pmin;
        logic [NP_W-1:0] np;
        logic [NB_W-1:0] nb;
        int pick;
        pick = $urandom_range(0, 3);
        if (pick < 2)
            pm = 32'($urandom_range(0, 4000)) - 32'd2000;
        else if (pick == 2)
            pm = $urandom();
        else
            pm = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            bw = 31'($urandom_range(1, 64));
        else if (pick < 7)
            bw = 31'($urandom_range(65, 65536));
        else if (pick < 9)
            bw = 31'($urandom_range(65537, 1 << 22));
        else
            bw = 31'h7FFF_FFFF;
        pick = $urandom_range(0, 4);
        if (pick < 3)
            pmin = 32'($urandom_range(0, 2000)) - 32'd1000;
        else if (pick == 3)
            pmin = $urandom();
        else
            pmin = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            np = NP_W'($urandom_range(1, MAX_PULSES));
        else if (pick == 7)
            np = NP_W'(MAX_PULSES);
        else if (pick == 8)
            np = NP_W'($urandom_range(MAX_PULSES + 1, 127));
        else
            np = NP_W'(1);
        pick = $urandom_range(0, 9);
        if (pick < 7)
            nb = NB_W'($urandom_range(1, MAX_PHASE_BINS));
        else if (pick == 7)
            nb = NB_W'(MAX_PHASE_BINS);
        else if (pick == 8)
            nb = NB_W'($urandom_range(MAX_PHASE_BINS + 1, 511));
        else
            nb = NB_W'(1);
        apply_setting(pm, bw, pmin, np, nb);
    endtask

    // Mostly accumulates aimed at cells of the current setting, some aimed
    // just outside it, plus reads of the busy corner and random noise.
    task automatic run_chunk(input int n_items, input bit pause_mid, input bit hold_mid);
        int np_eff;
        int nb_eff;
        int rowi;
        int coli;
        int pick;
        longint ph_l;
        logic [31:0] ph;
        logic [31:0] wt;
        np_eff = (int'(cur_np) > MAX_PULSES) ? MAX_PULSES : int'(cur_np);
        nb_eff = (int'(cur_nb) > MAX_PHASE_BINS) ? MAX_PHASE_BINS : int'(cur_nb);
        for (int k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 0)
                wt = 32'($urandom_range(0, 2000)) - 32'd1000;
            else
                wt = $urandom();
            if (pick < 15)
            begin
                if ($urandom_range(0, 1) == 0)
                    offer_read(ROW_W'($urandom_range(0, 3)), COL_W'($urandom_range(0, 3)));
                else
                    offer_read(ROW_W'($urandom()), COL_W'($urandom()));
            end
            else if (pick < 30)
            begin
                offer_acc($urandom(), $urandom(), wt);
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    rowi = $urandom_range(0, ((np_eff > 4) ? 4 : np_eff) - 1);
                else
                    rowi = $urandom_range(0, np_eff - 1);
                if ($urandom_range(0, 1) == 0)
                    coli = $urandom_range(0, ((nb_eff > 4) ? 4 : nb_eff) - 1);
                else
                    coli = $urandom_range(0, nb_eff - 1);
                if ($urandom_range(0, 9) == 0)
                    rowi = $urandom_range(0, 1) ? -1 : np_eff;
                if ($urandom_range(0, 9) == 0)
                    coli = $urandom_range(0, 1) ? -1 : nb_eff;
                ph_l = longint'($signed(cur_pm)) + longint'(coli) * longint'(cur_bw)
                       + longint'($urandom_range(0, 32'(cur_bw) - 1));
                // A cell whose phase does not fit in 32 bits gets a random phase.
                if (ph_l < -(longint'(1) <<< 31) || ph_l >= (longint'(1) <<< 31))
                    ph = $urandom();
                else
                    ph = ph_l[31:0];
                offer_acc(ph, cur_pmin + 32'(rowi), wt);
            end
            if (pause_mid && k == n_items / 2)
            begin
                sender_stop();
                wait_drained();
            end
            if (hold_mid && k == n_items / 2)
                hold_ticket++;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: cleared store, field extremes and dropped items.
        offer_read(ROW_W'(0), COL_W'(0));
        offer_read(ROW_W'(63), COL_W'(255));
        offer_acc(32'd0, 32'd0, 32'd5);
        offer_acc(32'h00FF_FFFF, 32'd63, 32'h7FFF_FFFF);
        offer_acc(32'h00FF_FFFF, 32'd63, 32'h8000_0000);
        offer_acc(32'hFFFF_FFFF, 32'd0, 32'd9);
        offer_acc(32'h0100_0000, 32'd0, 32'd9);
        offer_acc(32'd0, 32'd64, 32'd9);
        offer_acc(32'h7FFF_FFFF, 32'h8000_0000, 32'd9);
        offer_read(ROW_W'(63), COL_W'(255));
        offer_read(ROW_W'(0), COL_W'(0));
        sender_stop();
        wait_drained();

        // Extreme edges: widest bin, lowest phase edge, highest pulse edge.
        apply_setting(32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, NP_W'(1), NB_W'(3));
        offer_acc(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd7);
        offer_acc(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        offer_acc(32'd0, 32'h8000_0000, 32'd7);
        offer_read(ROW_W'(0), COL_W'(2));
        sender_stop();
        wait_drained();

        // Zero bin width drops every accumulate.
        apply_setting(32'd0, 31'd0, 32'd0, NP_W'(MAX_PULSES), NB_W'(MAX_PHASE_BINS));
        offer_acc(32'd0, 32'd0, 32'd1);
        offer_acc(32'h0001_0000, 32'd1, 32'd1);
        sender_stop();
        wait_drained();

        // Zero counts drop everything, yet reads still return stored cells.
        apply_setting(32'd0, 31'd1, 32'd0, NP_W'(0), NB_W'(0));
        offer_acc(32'd0, 32'd0, 32'd1);
        offer_read(ROW_W'(0), COL_W'(0));
        sender_stop();
        wait_drained();

        // Counts above the store are clamped to its size.
        apply_setting(32'd0, 31'd1, 32'd0, NP_W'(127), NB_W'(511));
        offer_acc(32'd255, 32'd63, 32'd3);
        offer_acc(32'd256, 32'd0, 32'd3);
        offer_acc(32'd0, 32'd64, 32'd3);
        offer_acc(32'd7, 32'd2, 32'h8000_0000);
        offer_read(ROW_W'(2), COL_W'(7));

        // Random part under three back-pressure regimes.
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 0)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 74;
            end
            else if (ph == 1)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int c = 0; c < 5; c++)
            begin
                sender_stop();
                wait_drained();
                if (ph == 0 && c == 0)
                    apply_setting(32'd0, 31'd65536, 32'd0, NP_W'(MAX_PULSES),
                                  NB_W'(MAX_PHASE_BINS));
                else
                    random_setting();
                run_chunk(CHUNK_ITEMS, ph == 0 && c == 1, ph == 2 && c == 2);
            end
        end

        sender_stop();
        wait_drained();
        repeat (40) @(posedge clk);

        $display("Covered %0d items (%0d reads); %0d results checked, %0d landed, %0d dropped.",
                 chk.items_n, chk.reads_n, chk.checked_n, chk.landed_n, chk.dropped_n);
        $display("Register settings applied: %0d, with zero width, zero and clamped counts.",
                 n_settings);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("tb_pulse_phase_stack_binner_unit OK");
        else
            $display("tb_pulse_phase_stack_binner_unit NOT OK");
        $finish;
    end

endmodule

[pulse_phase_stack_binner_unit.f]
design/ppsb_pkg.sv
design/ppsb_ctrl.sv
design/ppsb_dpath.sv
design/pulse_phase_stack_binner_unit.sv
test/tb_pulse_phase_stack_binner_unit.sv
